### src/ehfx_pkg.sv
// Shared types and constants for the Ethernet/IP header field extractor.
// No dependencies.
package ehfx_pkg;

  localparam int unsigned ETH_HDR    = 14;
  localparam int unsigned IPV6_HDR   = 40;
  localparam int unsigned PORT_BYTES = 4;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;

  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

  localparam logic [3:0] IHL_MIN = 4'd5;

  typedef enum logic [1:0] {
    KIND_IPV4  = 2'd0,
    KIND_IPV6  = 2'd1,
    KIND_ARP   = 2'd2,
    KIND_OTHER = 2'd3
  } frame_kind_t;

  typedef enum logic [1:0] {
    TRANS_OTHER = 2'd0,
    TRANS_TCP   = 2'd1,
    TRANS_UDP   = 2'd2,
    TRANS_ICMP  = 2'd3
  } transport_kind_t;

  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [15:0] ethertype;
    logic [3:0]  ihl;
    logic [7:0]  protocol;
    logic [63:0] src_upper;
    logic [63:0] src_lower;
    logic [63:0] dst_upper;
    logic [63:0] dst_lower;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } frame_state_t;

  typedef struct packed {
    logic [47:0]     dest_mac;
    logic [47:0]     source_mac;
    frame_kind_t     frame_kind;
    logic [63:0]     src_addr_upper;
    logic [63:0]     src_addr_lower;
    logic [63:0]     dst_addr_upper;
    logic [63:0]     dst_addr_lower;
    transport_kind_t transport_kind;
    logic [15:0]     src_port;
    logic [15:0]     dst_port;
    logic [15:0]     frame_length;
    logic            truncated;
  } summary_t;

  // TCP/UDP ports start right after the IPv4 header; IHL below five counts as five.
  function automatic logic [6:0] ipv4_port_base(input logic [3:0] ihl);
    logic [3:0] eff;
    eff = (ihl < IHL_MIN) ? IHL_MIN : ihl;
    return 7'(ETH_HDR) + {1'b0, eff, 2'b00};
  endfunction

endpackage

### src/ehfx_capture.sv
// Per-frame byte counter and header field capture registers.
// Depends on ehfx_pkg.
module ehfx_capture #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [7:0]                frame_byte,
  input  logic                      frame_end,
  output ehfx_pkg::frame_state_t    st_nxt,
  output logic [LENGTH_BITS-1:0]    len_nxt
);
  import ehfx_pkg::*;

  logic [LENGTH_BITS-1:0] pos_r;
  frame_state_t           st_r;
  logic [LENGTH_BITS-1:0] port_base;
  logic [LENGTH_BITS-1:0] port_off;
  logic                   port_hit;

  always_comb begin
    st_nxt = st_r;
    port_base = LENGTH_BITS'(ipv4_port_base(st_r.ihl));
    port_off  = pos_r - port_base;
    port_hit  = 1'b0;

    for (int i = 0; i < 6; i++) begin
      if (pos_r == LENGTH_BITS'(i)) st_nxt.dest_mac[8*(5-i) +: 8] = frame_byte;
      if (pos_r == LENGTH_BITS'(6 + i)) st_nxt.source_mac[8*(5-i) +: 8] = frame_byte;
    end
    for (int i = 0; i < 2; i++) begin
      if (pos_r == LENGTH_BITS'(12 + i)) st_nxt.ethertype[8*(1-i) +: 8] = frame_byte;
    end

    if (pos_r >= LENGTH_BITS'(ETH_HDR)) begin
      if (st_r.ethertype == ETYPE_IPV4) begin
        if (pos_r == LENGTH_BITS'(14)) st_nxt.ihl = frame_byte[3:0];
        if (pos_r == LENGTH_BITS'(23)) st_nxt.protocol = frame_byte;
        for (int i = 0; i < 4; i++) begin
          if (pos_r == LENGTH_BITS'(26 + i)) st_nxt.src_lower[8*(3-i) +: 8] = frame_byte;
          if (pos_r == LENGTH_BITS'(30 + i)) st_nxt.dst_lower[8*(3-i) +: 8] = frame_byte;
        end
        port_hit = (pos_r >= port_base) && (port_off < LENGTH_BITS'(PORT_BYTES));
      end else if (st_r.ethertype == ETYPE_IPV6) begin
        if (pos_r == LENGTH_BITS'(20)) st_nxt.protocol = frame_byte;
        for (int i = 0; i < 8; i++) begin
          if (pos_r == LENGTH_BITS'(22 + i)) st_nxt.src_upper[8*(7-i) +: 8] = frame_byte;
          if (pos_r == LENGTH_BITS'(30 + i)) st_nxt.src_lower[8*(7-i) +: 8] = frame_byte;
          if (pos_r == LENGTH_BITS'(38 + i)) st_nxt.dst_upper[8*(7-i) +: 8] = frame_byte;
          if (pos_r == LENGTH_BITS'(46 + i)) st_nxt.dst_lower[8*(7-i) +: 8] = frame_byte;
        end
        port_off = pos_r - LENGTH_BITS'(ETH_HDR + IPV6_HDR);
        port_hit = (pos_r >= LENGTH_BITS'(ETH_HDR + IPV6_HDR)) &&
                   (port_off < LENGTH_BITS'(PORT_BYTES));
      end
    end

    if (port_hit) begin
      case (port_off[1:0])
        2'd0:    st_nxt.src_port[15:8] = frame_byte;
        2'd1:    st_nxt.src_port[7:0]  = frame_byte;
        2'd2:    st_nxt.dst_port[15:8] = frame_byte;
        default: st_nxt.dst_port[7:0]  = frame_byte;
      endcase
    end

    // saturating byte count
    len_nxt = (&pos_r) ? pos_r : pos_r + LENGTH_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      st_r  <= '0;
    end else if (step) begin
      if (frame_end) begin
        pos_r <= '0;
        st_r  <= '0;
      end else begin
        pos_r <= len_nxt;
        st_r  <= st_nxt;
      end
    end
  end

endmodule

### src/ehfx_summary.sv
// Frame classification and summary formation from the captured header fields.
// Depends on ehfx_pkg.
module ehfx_summary #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  ehfx_pkg::frame_state_t  st,
  input  logic [LENGTH_BITS-1:0]  len,
  output ehfx_pkg::summary_t      res
);
  import ehfx_pkg::*;

  localparam int unsigned CW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

  frame_kind_t     kind;
  transport_kind_t tkind;
  logic [6:0]      need;
  logic            is_ip;
  logic            has_ports;
  logic [CW-1:0]   len_ext;

  always_comb begin
    len_ext = CW'(len);
    kind    = KIND_OTHER;
    tkind   = TRANS_OTHER;
    need    = 7'(ETH_HDR);

    if (len >= LENGTH_BITS'(ETH_HDR)) begin
      if (st.ethertype == ETYPE_IPV4)      kind = KIND_IPV4;
      else if (st.ethertype == ETYPE_IPV6) kind = KIND_IPV6;
      else if (st.ethertype == ETYPE_ARP)  kind = KIND_ARP;
    end

    case (kind)
      KIND_IPV4: begin
        if (len > LENGTH_BITS'(23)) begin
          if (st.protocol == PROTO_TCP)       tkind = TRANS_TCP;
          else if (st.protocol == PROTO_UDP)  tkind = TRANS_UDP;
          else if (st.protocol == PROTO_ICMP) tkind = TRANS_ICMP;
        end
      end
      KIND_IPV6: begin
        if (len > LENGTH_BITS'(20)) begin
          if (st.protocol == PROTO_TCP)         tkind = TRANS_TCP;
          else if (st.protocol == PROTO_UDP)    tkind = TRANS_UDP;
          else if (st.protocol == PROTO_ICMPV6) tkind = TRANS_ICMP;
        end
      end
      default: tkind = TRANS_OTHER;
    endcase

    is_ip     = (kind == KIND_IPV4) || (kind == KIND_IPV6);
    has_ports = (tkind == TRANS_TCP) || (tkind == TRANS_UDP);

    if (kind == KIND_IPV4) begin
      need = has_ports ? ipv4_port_base(st.ihl) + 7'(PORT_BYTES) : 7'd34;
    end else if (kind == KIND_IPV6) begin
      need = has_ports ? 7'(ETH_HDR + IPV6_HDR + PORT_BYTES) : 7'(ETH_HDR + IPV6_HDR);
    end

    res.dest_mac       = st.dest_mac;
    res.source_mac     = st.source_mac;
    res.frame_kind     = kind;
    res.src_addr_upper = is_ip ? st.src_upper : '0;
    res.src_addr_lower = is_ip ? st.src_lower : '0;
    res.dst_addr_upper = is_ip ? st.dst_upper : '0;
    res.dst_addr_lower = is_ip ? st.dst_lower : '0;
    res.transport_kind = tkind;
    res.src_port       = has_ports ? st.src_port : '0;
    res.dst_port       = has_ports ? st.dst_port : '0;
    res.frame_length   = (len_ext > CW'(16'hFFFF)) ? 16'hFFFF : len_ext[15:0];
    res.truncated      = (len_ext < CW'(need));
  end

endmodule

### src/ethernet_ip_header_field_extractor_unit.sv
// Ethernet/IPv4/IPv6 header field extractor, top level.
// A frame's last byte passes the input register; its summary is then captured in the output register.
// Throughput: one byte per cycle except while stalled; input register, capture logic, output register.
// The input stalls only on a last byte while an unread summary waits.
// Reset (rst_n low, synchronous) clears byte count, captured fields and valids.
// Depends on ehfx_pkg, ehfx_capture, ehfx_summary.
module ethernet_ip_header_field_extractor_unit #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] out_dest_mac,
  output logic [47:0] out_source_mac,
  output logic [1:0]  out_frame_kind,
  output logic [63:0] out_src_addr_upper,
  output logic [63:0] out_src_addr_lower,
  output logic [63:0] out_dst_addr_upper,
  output logic [63:0] out_dst_addr_lower,
  output logic [1:0]  out_transport_kind,
  output logic [15:0] out_src_port,
  output logic [15:0] out_dst_port,
  output logic [15:0] out_frame_length,
  output logic        out_truncated
);
  import ehfx_pkg::*;

  logic                   in_valid_r;
  logic [7:0]             in_byte_r;
  logic                   in_end_r;
  logic                   step;
  logic                   out_valid_r;
  summary_t               res_r;
  summary_t               res;
  frame_state_t           st_nxt;
  logic [LENGTH_BITS-1:0] len_nxt;

  // a last byte may only advance when the output register can take its summary
  assign step     = in_valid_r && (!in_end_r || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_frame_byte;
      in_end_r  <= in_frame_end;
    end
  end

  ehfx_capture #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .frame_byte(in_byte_r),
    .frame_end (in_end_r),
    .st_nxt    (st_nxt),
    .len_nxt   (len_nxt)
  );

  ehfx_summary #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_summary (
    .st (st_nxt),
    .len(len_nxt),
    .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && in_end_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_end_r) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_dest_mac       = res_r.dest_mac;
  assign out_source_mac     = res_r.source_mac;
  assign out_frame_kind     = res_r.frame_kind;
  assign out_src_addr_upper = res_r.src_addr_upper;
  assign out_src_addr_lower = res_r.src_addr_lower;
  assign out_dst_addr_upper = res_r.dst_addr_upper;
  assign out_dst_addr_lower = res_r.dst_addr_lower;
  assign out_transport_kind = res_r.transport_kind;
  assign out_src_port       = res_r.src_port;
  assign out_dst_port       = res_r.dst_port;
  assign out_frame_length   = res_r.frame_length;
  assign out_truncated      = res_r.truncated;

endmodule
